// ----- rtl/lru_block_buffer_assert.svh -----
// Assertion macros for the LRU block buffer.
// Expects clk and arst_n in the scope of every use.
`ifndef LRU_BLOCK_BUFFER_ASSERT_SVH
`define LRU_BLOCK_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LBB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lru_block_buffer: assertion failed");

// Next-cycle implication, disabled during reset.
`define LBB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lru_block_buffer: assertion failed");

`endif

// ----- rtl/lbb_pkg.sv -----
// Shared types and constants of the LRU block buffer.
// No dependencies; lbb_ifs, lbb_cell and lru_block_buffer use it.
`timescale 1ns / 1ps

package lbb_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int TAG_BITS   = 16;
	localparam int LIMIT_W    = 5;
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int LIMIT_RST  = 16;

	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [LIMIT_W-1:0]  limit_t;
	typedef logic [1:0]          op_t;

	localparam op_t OP_READ  = 2'd0;
	localparam op_t OP_PROBE = 2'd1;
	localparam op_t OP_WRITE = 2'd2;

	// per-cell control from the top level
	typedef struct packed {
		logic valid;    // cell holds a live entry
		logic touch;    // read hit: cells up to the hit slide back
		logic wr_take;  // write: cell takes its neighbor's tags
	} cell_ctl_t;

endpackage

// ----- rtl/lbb_ifs.sv -----
// Channel interfaces of the LRU block buffer: request, response, config.
// Depends on lbb_pkg.
`timescale 1ns / 1ps

interface lbb_req_if;
	logic                   valid;
	logic                   ready;
	logic [1:0]             op;
	logic [lbb_pkg::TAG_BITS-1:0] file_tag;
	logic [lbb_pkg::TAG_BITS-1:0] segment_tag;

	modport source (output valid, op, file_tag, segment_tag, input ready);
	modport sink   (input valid, op, file_tag, segment_tag, output ready);
endinterface

interface lbb_rsp_if;
	logic                   valid;
	logic                   ready;
	logic                   hit;
	logic                   evicted_valid;
	logic [lbb_pkg::TAG_BITS-1:0] evicted_file;
	logic [lbb_pkg::TAG_BITS-1:0] evicted_segment;

	modport source (output valid, hit, evicted_valid, evicted_file, evicted_segment,
		input ready);
	modport sink   (input valid, hit, evicted_valid, evicted_file, evicted_segment,
		output ready);
endinterface

interface lbb_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lbb_pkg::LIMIT_W-1:0]   block_limit;

	modport source (output valid, block_limit, input ready);
	modport sink   (input valid, block_limit, output ready);
endinterface

// ----- rtl/lbb_cell.sv -----
// One entry of the recency chain: holds a tag pair, compares it with the
// request and takes its front neighbor's tags on a reorder. Depends on lbb_pkg.
`timescale 1ns / 1ps

module lbb_cell (
	input  logic              clk,
	input  lbb_pkg::cell_ctl_t ctl,
	input  logic              acc,
	input  lbb_pkg::tag_t     req_file,
	input  lbb_pkg::tag_t     req_segment,
	input  lbb_pkg::tag_t     prev_file,
	input  lbb_pkg::tag_t     prev_segment,
	input  logic              prev_found,
	output lbb_pkg::tag_t     file_q,
	output lbb_pkg::tag_t     segment_q,
	output logic              found
);
	import lbb_pkg::*;

	logic match;
	logic take;

	assign match = ctl.valid && (file_q == req_file) && (segment_q == req_segment);
	assign found = prev_found | match;
	assign take  = acc && ((ctl.touch && !prev_found) || ctl.wr_take);

	always_ff @(posedge clk) begin
		if (take) begin
			file_q    <= prev_file;
			segment_q <= prev_segment;
		end
	end

endmodule

// ----- rtl/lru_block_buffer.sv -----
// Top level of the LRU block buffer: request/response/config channels,
// fill count, eviction select and the row of lbb_cell entries.
// Depends on lbb_pkg, lbb_ifs, lbb_cell and lru_block_buffer_assert.svh.
//
// Use: send one operation per transfer on req (op 0 read and touch, 1 probe,
// 2 write insert) with a file and segment tag. Every request yields exactly
// one transfer on rsp: hit for reads and probes, the evicted tag pair for
// writes that find the buffer at its limit. cfg sets block_limit (1..16);
// write it only while no request is in flight.
// Response: registered, valid in the cycle after the request transfer.
// Throughput: one request per cycle while rsp takes each response; all cells
// compare in parallel and the reorder is a registered shift along the chain,
// so the compare chain plus the cell update sets the cycle.
// Reset: the buffer empties (fill count 0), block_limit returns to 16, the
// response register empties. Tags in the cells are not cleared.
// Stall: a held response occupies the output register; req.ready drops
// until rsp takes it, so no request is lost or reordered.
`timescale 1ns / 1ps
`include "lru_block_buffer_assert.svh"

module lru_block_buffer (
	input  logic     clk,
	input  logic     arst_n,
	lbb_req_if.sink   req,
	lbb_rsp_if.source rsp,
	lbb_cfg_if.sink   cfg
);
	import lbb_pkg::*;

	limit_t    limit_q;
	cnt_t      fill_q;
	cnt_t      lim_eff;
	logic      full;
	logic      acc;
	logic      hit;
	idx_t      ev_idx;
	cell_ctl_t ctl [MAX_BLOCKS];
	tag_t      cell_file [MAX_BLOCKS];
	tag_t      cell_segment [MAX_BLOCKS];
	tag_t      prev_file [MAX_BLOCKS];
	tag_t      prev_segment [MAX_BLOCKS];
	logic      found [MAX_BLOCKS+1];

	logic      rsp_valid_q;
	logic      hit_q;
	logic      ev_q;
	tag_t      ev_file_q;
	tag_t      ev_segment_q;

	assign cfg.ready = 1'b1;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;

	always_comb begin
		if (limit_q == '0) begin
			lim_eff = cnt_t'(1);
		end else if (32'(limit_q) > 32'(MAX_BLOCKS)) begin
			lim_eff = cnt_t'(MAX_BLOCKS);
		end else begin
			lim_eff = cnt_t'(limit_q);
		end
	end

	assign full   = fill_q >= lim_eff;
	assign hit    = found[MAX_BLOCKS];
	assign ev_idx = idx_t'(fill_q - cnt_t'(1));

	always_comb begin
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			ctl[i].valid   = cnt_t'(i) < fill_q;
			ctl[i].touch   = (req.op == OP_READ) && hit;
			ctl[i].wr_take = (req.op == OP_WRITE) &&
				((cnt_t'(i) < fill_q) || ((cnt_t'(i) == fill_q) && !full));
		end
	end

	assign found[0] = 1'b0;

	for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign prev_file[g]    = req.file_tag;
			assign prev_segment[g] = req.segment_tag;
		end else begin : g_body
			assign prev_file[g]    = cell_file[g-1];
			assign prev_segment[g] = cell_segment[g-1];
		end

		lbb_cell u_cell (
			.clk          (clk),
			.ctl          (ctl[g]),
			.acc          (acc),
			.req_file     (req.file_tag),
			.req_segment  (req.segment_tag),
			.prev_file    (prev_file[g]),
			.prev_segment (prev_segment[g]),
			.prev_found   (found[g]),
			.file_q       (cell_file[g]),
			.segment_q    (cell_segment[g]),
			.found        (found[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= limit_t'(LIMIT_RST);
		end else if (cfg.valid && cfg.ready) begin
			limit_q <= cfg.block_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (acc && (req.op == OP_WRITE) && !full) begin
			fill_q <= fill_q + cnt_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (acc) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			hit_q <= ((req.op == OP_READ) || (req.op == OP_PROBE)) && hit;
			if ((req.op == OP_WRITE) && full) begin
				ev_q         <= 1'b1;
				ev_file_q    <= cell_file[ev_idx];
				ev_segment_q <= cell_segment[ev_idx];
			end else begin
				ev_q         <= 1'b0;
				ev_file_q    <= '0;
				ev_segment_q <= '0;
			end
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.hit             = hit_q;
	assign rsp.evicted_valid   = ev_q;
	assign rsp.evicted_file    = ev_file_q;
	assign rsp.evicted_segment = ev_segment_q;

	`LBB_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= cnt_t'(MAX_BLOCKS))
	`LBB_ASSERT_NOW(a_hit_excl_evict, rsp_valid_q, !(hit_q && ev_q))
	`LBB_ASSERT_NEXT(a_fill_grow, acc && (req.op == OP_WRITE) && !full,
		fill_q == $past(fill_q) + cnt_t'(1))
	`LBB_ASSERT_NEXT(a_stall_hold, rsp_valid_q && !rsp.ready, rsp_valid_q && $stable(hit_q))

endmodule
